// ----- hdl/tst_pkg.sv -----
// Shared types, constants and lookup functions for the script tokenizer.
package tst_pkg;

    // Fixed field widths
    localparam int BYTE_W      = 8;
    localparam int KIND_W      = 6;
    localparam int START_W     = 16;
    localparam int LEN_W       = 16;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 40;

    // Defaults for the top-level parameters
    localparam int MAX_KEYWORD_LEN_DEF = 7;
    localparam int POS_WIDTH_DEF       = 16;

    // Keyword and punctuation table
    localparam int ENTRY_COUNT   = 29;
    localparam int ENTRY_MAX_LEN = 7;
    localparam int ENTRY_TEXT_W  = ENTRY_MAX_LEN * BYTE_W;
    localparam int ENTRY_LEN_W   = 4;

    // Token kinds beyond the table entries
    localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd29;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 6'd30;
    localparam logic [KIND_W-1:0] KIND_END    = 6'd31;
    localparam logic [KIND_W-1:0] KIND_ERROR  = 6'd32;

    // Input queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_INT,
        MODE_FRAC
    } scan_mode_t;

    typedef struct packed {
        logic space;
        logic digit;
        logic idstart;
    } char_cls_t;

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        char_cls_t         cls;
    } win_ent_t;

    localparam int ENT_W = $bits(win_ent_t);

    typedef struct packed {
        logic [BYTE_W-1:0] text;
        char_cls_t         cls;
        logic              end_mark;
    } queue_item_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   len;
    } token_t;

    typedef struct packed {
        logic   emit;
        logic   run_end;
        token_t tok;
    } tok_event_t;

    typedef struct packed {
        logic active;
        logic halted;
        logic win_full;
    } core_stat_t;

    // Classify one text byte
    function automatic char_cls_t classify(input logic [BYTE_W-1:0] c);
        char_cls_t r;
        r.space   = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
        r.digit   = (c >= 8'h30 && c <= 8'h39);
        r.idstart = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                    (c == 8'h5F);
        return r;
    endfunction

    // Entry text, first character in the lowest byte
    function automatic logic [ENTRY_TEXT_W-1:0] entry_text(input logic [KIND_W-1:0] k);
        logic [ENTRY_TEXT_W-1:0] r;
        case (k)
            6'd0:    r = 56'("elit");
            6'd1:    r = 56'("xetrev");
            6'd2:    r = 56'("egde");
            6'd3:    r = 56'("fi");
            6'd4:    r = 56'("esle");
            6'd5:    r = 56'("yal");
            6'd6:    r = 56'("uaelbat");
            6'd7:    r = 56'("soc");
            6'd8:    r = 56'("nis");
            6'd9:    r = 56'("[");
            6'd10:   r = 56'("]");
            6'd11:   r = 56'("{");
            6'd12:   r = 56'("}");
            6'd13:   r = 56'("(");
            6'd14:   r = 56'(")");
            6'd15:   r = 56'("+");
            6'd16:   r = 56'("-");
            6'd17:   r = 56'("/");
            6'd18:   r = 56'("*");
            6'd19:   r = 56'("^");
            6'd20:   r = 56'(";");
            6'd21:   r = 56'(".");
            6'd22:   r = 56'("$");
            6'd23:   r = 56'("=:");
            6'd24:   r = 56'("=");
            6'd25:   r = 56'("=!");
            6'd26:   r = 56'("&");
            6'd27:   r = 56'("|");
            6'd28:   r = 56'("!");
            default: r = '0;
        endcase
        return r;
    endfunction

    // Entry length in bytes
    function automatic logic [ENTRY_LEN_W-1:0] entry_len(input logic [KIND_W-1:0] k);
        logic [ENTRY_LEN_W-1:0] r;
        case (k)
            6'd0, 6'd2, 6'd4:       r = 4'd4;
            6'd1:                   r = 4'd6;
            6'd3, 6'd23, 6'd25:     r = 4'd2;
            6'd5, 6'd7, 6'd8:       r = 4'd3;
            6'd6:                   r = 4'd7;
            default:                r = 4'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- hdl/tiling_script_tokenizer_core.sv -----
// Top level of the script tokenizer: byte stream in, token stream out.
// Text bytes enter on the s_ stream (tlast marks end of text and carries no
// character) and land in a four-entry queue. A scanner then works through a
// lookahead window of MAX_KEYWORD_LEN+1 bytes, one scan step per cycle unless
// a token meets a full output stage: an identifier, number or whitespace
// byte is one step, each token decided takes one step of its own, and a byte
// leaving a keyword prefix or a "digits ." open ends its request in one step.
// At most one token leaves per cycle through a held token and an output
// register, so the last token of each request can carry tlast. End of text
// flushes pending tokens, sends an end token and starts a new text at
// offset 0. An unknown character sends an error token, after which input is
// drained silently until reset. There is no clearing pass after reset.
module tiling_script_tokenizer_core #(
    parameter int MAX_KEYWORD_LEN = tst_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int POS_WIDTH       = tst_pkg::POS_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [tst_pkg::IN_TDATA_W-1:0]     s_tdata,   // [7:0] text_byte
    input  logic                               s_tlast,   // end_marker
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [tst_pkg::OUT_TDATA_W-1:0]    m_tdata,   // [5:0] token_kind,
                                                          // [21:6] token_start,
                                                          // [37:22] token_length
    output logic                               m_tlast    // last_of_run
);

    logic                 head_valid;
    tst_pkg::queue_item_t head;
    logic                 pop;
    logic                 can_take;
    tst_pkg::tok_event_t  ev;
    tst_pkg::core_stat_t  stat;

    tst_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    tst_back #(
        .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
        .POS_WIDTH       (POS_WIDTH)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .can_take   (can_take),
        .ev         (ev),
        .stat       (stat)
    );

    tst_out u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ev       (ev),
        .can_take (can_take),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Halt lasts until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.halted |=> stat.halted)
        else $error("halt cleared without reset");

    // A halted scanner works on no request
    a_halt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.halted |-> !stat.active)
        else $error("scanner active while halted");

    // The window never fills up completely
    a_win_room: assert property (@(posedge aclk) disable iff (!aresetn)
        !stat.win_full)
        else $error("lookahead window overflow");

    // Only defined token kinds leave the block
    a_kind_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5:0] <= tst_pkg::KIND_ERROR))
        else $error("token kind out of range");

endmodule

// ----- hdl/tst_front.sv -----
// Front end: accepts text bytes, classifies them and queues them for the scanner.
module tst_front (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [tst_pkg::IN_TDATA_W-1:0] s_tdata,   // [7:0] text_byte
    input  logic                   s_tlast,           // end_marker
    output logic                   head_valid,
    output tst_pkg::queue_item_t   head,
    input  logic                   pop
);

    tst_pkg::queue_item_t              mem_reg [tst_pkg::QUEUE_DEPTH];
    logic [tst_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [tst_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [tst_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                              push;
    logic                              pull;
    tst_pkg::queue_item_t              item;

    // Classify the incoming request
    always_comb begin
        item.text     = s_tdata[tst_pkg::BYTE_W-1:0];
        item.cls      = tst_pkg::classify(s_tdata[tst_pkg::BYTE_W-1:0]);
        item.end_mark = s_tlast;
    end

    assign s_tready   = (count_reg != tst_pkg::QCNT_W'(tst_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = mem_reg[rd_ptr_reg];
    assign push       = s_tvalid && s_tready;
    assign pull       = pop && head_valid;

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pull ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pull) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pull) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the request payload
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- hdl/tst_back.sv -----
// Back end: lookahead window and scan sequencer, one scan step per cycle unless a token meets a full output stage.
module tst_back #(
    parameter int MAX_KEYWORD_LEN = tst_pkg::MAX_KEYWORD_LEN_DEF,
    parameter int POS_WIDTH       = tst_pkg::POS_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 head_valid,
    input  tst_pkg::queue_item_t head,
    output logic                 pop,
    input  logic                 can_take,
    output tst_pkg::tok_event_t  ev,
    output tst_pkg::core_stat_t  stat
);

    localparam int WIN_DEPTH = MAX_KEYWORD_LEN + 1;
    localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
    localparam int ENT_W     = tst_pkg::ENT_W;
    localparam int LEN_W     = tst_pkg::LEN_W;

    logic [WIN_DEPTH*ENT_W-1:0] win_reg, win_next, win_base, win_shift;
    logic [FILL_W-1:0]          fill_reg, fill_next, fill_base;
    logic [POS_WIDTH-1:0]       pos_reg, pos_next, pos_base;
    tst_pkg::scan_mode_t        mode_reg, mode_next, mode_base;
    logic [POS_WIDTH-1:0]       tok_begin_reg, tok_begin_next, tok_begin_base;
    logic [LEN_W-1:0]           tlen_reg, tlen_next, tlen_base;
    logic                       halted_reg, halted_next, halted_base;
    logic                       active_reg, active_next;
    logic                       final_reg, final_next;

    tst_pkg::win_ent_t          w0, w1;

    // Table match results
    logic                       hit_found, hit_wait;
    logic [tst_pkg::KIND_W-1:0] hit_kind;
    logic [tst_pkg::ENTRY_LEN_W-1:0] hit_len;

    // Step decision
    logic [FILL_W-1:0]          cons;
    logic                       do_take, set_begin, emit, run_end, do_clear, do_halt;
    tst_pkg::scan_mode_t        mode_dec;
    logic [tst_pkg::KIND_W-1:0] e_kind;
    logic [POS_WIDTH-1:0]       e_start;
    logic [LEN_W-1:0]           e_len;

    logic                       step_go, item_end, can_load;
    logic [POS_WIDTH:0]         pos_sum;
    logic [LEN_W:0]             len_sum;
    logic [31:0]                start32;
    tst_pkg::win_ent_t          new_ent;

    assign w0 = tst_pkg::win_ent_t'(win_reg[ENT_W-1:0]);
    assign w1 = tst_pkg::win_ent_t'(win_reg[2*ENT_W-1:ENT_W]);

    // Find the first table entry that fits the window or may fit once more text arrives
    always_comb begin : match
        logic [tst_pkg::ENTRY_TEXT_W-1:0] txt;
        logic [tst_pkg::ENTRY_LEN_W-1:0]  elen;
        logic                             ok;
        logic                             fit_yes, fit_wait;
        tst_pkg::win_ent_t                we;
        hit_found = 1'b0;
        hit_wait  = 1'b0;
        hit_kind  = '0;
        hit_len   = '0;
        for (int k = 0; k < tst_pkg::ENTRY_COUNT; k++) begin
            txt  = tst_pkg::entry_text(tst_pkg::KIND_W'(k));
            elen = tst_pkg::entry_len(tst_pkg::KIND_W'(k));
            ok   = 1'b1;
            for (int i = 0; i < tst_pkg::ENTRY_MAX_LEN; i++) begin
                we = tst_pkg::win_ent_t'(win_reg[i*ENT_W +: ENT_W]);
                if ((i < 32'(elen)) && (i < 32'(fill_reg)) &&
                    (we.text != txt[i*tst_pkg::BYTE_W +: tst_pkg::BYTE_W])) begin
                    ok = 1'b0;
                end
            end
            fit_yes  = ok && (32'(fill_reg) >= 32'(elen));
            fit_wait = ok && (32'(fill_reg) < 32'(elen)) && !final_reg;
            if (!hit_found && (fit_yes || fit_wait)) begin
                hit_found = 1'b1;
                hit_wait  = fit_wait;
                hit_kind  = tst_pkg::KIND_W'(k);
                hit_len   = elen;
            end
        end
    end

    // Decide one scan step
    always_comb begin : decide
        logic finish;
        cons      = '0;
        do_take   = 1'b0;
        set_begin = 1'b0;
        emit      = 1'b0;
        run_end   = 1'b0;
        do_clear  = 1'b0;
        do_halt   = 1'b0;
        finish    = 1'b0;
        mode_dec  = mode_reg;
        e_kind    = tst_pkg::KIND_END;
        e_start   = pos_reg;
        e_len     = '0;
        case (mode_reg)
            tst_pkg::MODE_IDLE: begin
                if (fill_reg == '0) begin
                    run_end = 1'b1;
                    if (final_reg) begin
                        emit     = 1'b1;
                        do_clear = 1'b1;
                    end
                end else if (w0.cls.space) begin
                    cons = FILL_W'(1);
                end else if (hit_found) begin
                    if (hit_wait) begin
                        run_end = 1'b1;
                    end else begin
                        emit   = 1'b1;
                        e_kind = hit_kind;
                        e_len  = LEN_W'(hit_len);
                        cons   = FILL_W'(hit_len);
                    end
                end else if (w0.cls.digit || w0.cls.idstart) begin
                    mode_dec  = w0.cls.digit ? tst_pkg::MODE_INT : tst_pkg::MODE_IDENT;
                    set_begin = 1'b1;
                    cons      = FILL_W'(1);
                end else begin
                    emit    = 1'b1;
                    e_kind  = tst_pkg::KIND_ERROR;
                    do_halt = 1'b1;
                    run_end = 1'b1;
                end
            end
            default: begin
                if (fill_reg == '0) begin
                    if (final_reg) begin
                        finish = 1'b1;
                    end else begin
                        run_end = 1'b1;
                    end
                end else begin
                    case (mode_reg)
                        tst_pkg::MODE_IDENT: begin
                            if (w0.cls.idstart || w0.cls.digit) begin
                                do_take = 1'b1;
                                cons    = FILL_W'(1);
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        tst_pkg::MODE_INT: begin
                            if (w0.cls.digit) begin
                                do_take = 1'b1;
                                cons    = FILL_W'(1);
                            end else if (w0.text == 8'h2E) begin
                                if (fill_reg < FILL_W'(2)) begin
                                    if (final_reg) begin
                                        finish = 1'b1;
                                    end else begin
                                        run_end = 1'b1;
                                    end
                                end else if (w1.cls.digit) begin
                                    do_take  = 1'b1;
                                    cons     = FILL_W'(2);
                                    mode_dec = tst_pkg::MODE_FRAC;
                                end else begin
                                    finish = 1'b1;
                                end
                            end else begin
                                finish = 1'b1;
                            end
                        end
                        default: begin
                            if (w0.cls.digit) begin
                                do_take = 1'b1;
                                cons    = FILL_W'(1);
                            end else begin
                                finish = 1'b1;
                            end
                        end
                    endcase
                end
                if (finish) begin
                    emit     = 1'b1;
                    e_kind   = (mode_reg == tst_pkg::MODE_IDENT) ? tst_pkg::KIND_IDENT
                                                                 : tst_pkg::KIND_NUMBER;
                    e_start  = tok_begin_reg;
                    e_len    = tlen_reg;
                    mode_dec = tst_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    assign step_go = active_reg && (!emit || can_take);

    // Apply the step to the scan state
    always_comb begin : apply
        win_shift      = win_reg >> (32'(cons) * ENT_W);
        pos_sum        = {1'b0, pos_reg} + (POS_WIDTH + 1)'(cons);
        len_sum        = {1'b0, tlen_reg} + (LEN_W + 1)'(cons);
        win_base       = win_reg;
        fill_base      = fill_reg;
        pos_base       = pos_reg;
        mode_base      = mode_reg;
        tok_begin_base = tok_begin_reg;
        tlen_base      = tlen_reg;
        halted_base    = halted_reg;
        item_end       = 1'b0;
        if (step_go) begin
            win_base  = win_shift;
            fill_base = fill_reg - cons;
            pos_base  = pos_sum[POS_WIDTH] ? {POS_WIDTH{1'b1}} : pos_sum[POS_WIDTH-1:0];
            mode_base = mode_dec;
            if (set_begin) begin
                tok_begin_base = pos_reg;
                tlen_base      = LEN_W'(1);
            end else if (do_take) begin
                tlen_base = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];
            end
            if (do_halt) begin
                halted_base = 1'b1;
                fill_base   = '0;
            end
            if (do_clear) begin
                fill_base      = '0;
                pos_base       = '0;
                mode_base      = tst_pkg::MODE_IDLE;
                tok_begin_base = '0;
                tlen_base      = '0;
            end
            // An empty window with more text to come ends the run at once
            item_end = run_end || (!final_reg && (fill_base == '0));
        end
    end

    // Load the next queued request into the window
    always_comb begin : load
        new_ent.text = head.text;
        new_ent.cls  = head.cls;
        can_load     = head_valid && !halted_base && (!active_reg || item_end);
        pop          = can_load || (halted_reg && head_valid);
        win_next       = win_base;
        fill_next      = fill_base;
        pos_next       = pos_base;
        mode_next      = mode_base;
        tok_begin_next = tok_begin_base;
        tlen_next      = tlen_base;
        halted_next    = halted_base;
        active_next    = active_reg && !item_end;
        final_next     = final_reg;
        if (can_load) begin
            active_next = 1'b1;
            final_next  = head.end_mark;
            if (!head.end_mark && (fill_base < FILL_W'(WIN_DEPTH))) begin
                for (int i = 0; i < WIN_DEPTH; i++) begin
                    if (FILL_W'(i) == fill_base) begin
                        win_next[i*ENT_W +: ENT_W] = new_ent;
                    end
                end
                fill_next = fill_base + 1'b1;
            end
        end
    end

    // Report the step to the output stage
    always_comb begin : report
        start32        = 32'(e_start);
        ev.emit        = step_go && emit;
        ev.run_end     = item_end;
        ev.tok.kind    = e_kind;
        ev.tok.start   = (start32 > 32'd65535) ? 16'hFFFF : start32[15:0];
        ev.tok.len     = e_len;
        stat.active    = active_reg;
        stat.halted    = halted_reg;
        stat.win_full  = (fill_reg == FILL_W'(WIN_DEPTH));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            pos_reg       <= '0;
            mode_reg      <= tst_pkg::MODE_IDLE;
            tok_begin_reg <= '0;
            tlen_reg      <= '0;
            halted_reg    <= 1'b0;
            active_reg    <= 1'b0;
            final_reg     <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            pos_reg       <= pos_next;
            mode_reg      <= mode_next;
            tok_begin_reg <= tok_begin_next;
            tlen_reg      <= tlen_next;
            halted_reg    <= halted_next;
            active_reg    <= active_next;
            final_reg     <= final_next;
        end
    end

    // Hold window bytes
    always_ff @(posedge aclk) begin
        win_reg <= win_next;
    end

endmodule

// ----- hdl/tst_out.sv -----
// Output stage: holds the newest token until its last flag is known, then registers it out.
module tst_out (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  tst_pkg::tok_event_t  ev,
    output logic                 can_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [tst_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic            hold_valid_reg, hold_valid_next;
    logic            hold_last_reg, hold_last_next;
    tst_pkg::token_t hold_tok_reg, hold_tok_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_last_reg;
    tst_pkg::token_t out_tok_reg;
    logic            out_free;
    logic            push;

    assign out_free = !out_valid_reg || m_tready;
    assign can_take = !hold_valid_reg || out_free;
    assign push     = hold_valid_reg && out_free && (hold_last_reg || ev.emit);

    // Replace, drain or seal the held token
    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_last_next  = hold_last_reg;
        hold_tok_next   = hold_tok_reg;
        if (ev.emit) begin
            hold_valid_next = 1'b1;
            hold_last_next  = ev.run_end;
            hold_tok_next   = ev.tok;
        end else if (push) begin
            hold_valid_next = 1'b0;
        end else if (ev.run_end && hold_valid_reg) begin
            hold_last_next = 1'b1;
        end
        out_valid_next = push || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            hold_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            hold_last_reg  <= hold_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold payloads
    always_ff @(posedge aclk) begin
        hold_tok_reg <= hold_tok_next;
        if (push) begin
            out_tok_reg  <= hold_tok_reg;
            out_last_reg <= hold_last_reg || ev.emit == 1'b0 ? hold_last_reg : 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_tok_reg.len, out_tok_reg.start, out_tok_reg.kind};

endmodule

// ----- bench/tb_tiling_script_tokenizer_core.sv -----
// Self-checking testbench for the script tokenizer core with a built-in token predictor.
module tb_tiling_script_tokenizer_core;

    localparam int WIN_DEPTH   = tst_pkg::MAX_KEYWORD_LEN_DEF + 1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic [tst_pkg::BYTE_W-1:0] text_byte;
        logic                       end_marker;
        bit                         drain_first;
    } text_req_t;

    typedef struct {
        logic [tst_pkg::KIND_W-1:0]  kind;
        logic [tst_pkg::START_W-1:0] start;
        logic [tst_pkg::LEN_W-1:0]   len;
        logic                        last;
    } token_exp_t;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [tst_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            s_tlast  = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [tst_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tlast;

    text_req_t  text_queue[$];
    token_exp_t token_queue[$];
    bit         run_live;
    bit         req_taken;
    int         send_gap;
    int         stall_left;
    int         fail_count;
    int         cycle_count;
    int         bytes_sent;
    int         ends_sent;
    int         tokens_seen;
    int         kind_hits[64];

    // Predictor state
    logic [tst_pkg::BYTE_W-1:0]  lex_win[WIN_DEPTH];
    int                          lex_fill;
    logic [tst_pkg::START_W-1:0] lex_pos;
    tst_pkg::scan_mode_t         lex_mode;
    logic [tst_pkg::START_W-1:0] lex_begin;
    logic [tst_pkg::LEN_W-1:0]   lex_len;
    bit                          lex_halted;

    string kw_text[tst_pkg::ENTRY_COUNT] = '{"tile", "vertex", "edge", "if", "else", "lay",
        "tableau", "cos", "sin", "[", "]", "{", "}", "(", ")", "+", "-", "/", "*", "^", ";",
        ".", "$", ":=", "=", "!=", "&", "|", "!"};

    tiling_script_tokenizer_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    function automatic bit is_ws(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_start(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic void lex_clear();
        lex_fill   = 0;
        lex_pos    = '0;
        lex_mode   = tst_pkg::MODE_IDLE;
        lex_begin  = '0;
        lex_len    = '0;
        lex_halted = 1'b0;
    endfunction

    function automatic void lex_emit(int kind, logic [tst_pkg::START_W-1:0] start,
                                     logic [tst_pkg::LEN_W-1:0] len);
        token_exp_t t;
        t.kind  = tst_pkg::KIND_W'(kind);
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        token_queue.push_back(t);
    endfunction

    // Drop k bytes from the window front, advancing the saturating offset
    function automatic void lex_drop(int k);
        logic [tst_pkg::START_W:0] sum;
        if (k > lex_fill) k = lex_fill;
        for (int i = 0; i + k < lex_fill; i++) lex_win[i] = lex_win[i + k];
        lex_fill -= k;
        sum = {1'b0, lex_pos} + (tst_pkg::START_W + 1)'(k);
        lex_pos = sum[tst_pkg::START_W] ? '1 : sum[tst_pkg::START_W-1:0];
    endfunction

    function automatic void lex_take(int k);
        logic [tst_pkg::LEN_W:0] sum;
        sum = {1'b0, lex_len} + (tst_pkg::LEN_W + 1)'(k);
        lex_len = sum[tst_pkg::LEN_W] ? '1 : sum[tst_pkg::LEN_W-1:0];
        lex_drop(k);
    endfunction

    // 0 no fit, 1 needs more text, 2 fits
    function automatic int kw_fit(int k, bit final_step);
        int len;
        int m;
        len = kw_text[k].len();
        m = len < lex_fill ? len : lex_fill;
        for (int i = 0; i < m; i++)
            if (lex_win[i] != kw_text[k][i]) return 0;
        if (lex_fill >= len) return 2;
        return final_step ? 0 : 1;
    endfunction

    function automatic void lex_close();
        lex_emit(lex_mode == tst_pkg::MODE_IDENT ? tst_pkg::KIND_IDENT : tst_pkg::KIND_NUMBER,
                 lex_begin, lex_len);
        lex_mode = tst_pkg::MODE_IDLE;
    endfunction

    function automatic void lex_scan(bit final_step);
        int k;
        int fit;
        logic [7:0] c;
        forever begin
            if (lex_mode == tst_pkg::MODE_IDLE) begin
                while (lex_fill > 0 && is_ws(lex_win[0])) lex_drop(1);
                if (lex_fill == 0) begin
                    if (final_step) begin
                        lex_emit(tst_pkg::KIND_END, lex_pos, '0);
                        lex_clear();
                    end
                    return;
                end
                fit = 0;
                for (k = 0; k < tst_pkg::ENTRY_COUNT; k++) begin
                    fit = kw_fit(k, final_step);
                    if (fit != 0) break;
                end
                if (k < tst_pkg::ENTRY_COUNT) begin
                    if (fit == 1) return;
                    lex_emit(k, lex_pos, tst_pkg::LEN_W'(kw_text[k].len()));
                    lex_drop(kw_text[k].len());
                    continue;
                end
                c = lex_win[0];
                if (is_num(c) || is_word_start(c)) begin
                    lex_mode  = is_num(c) ? tst_pkg::MODE_INT : tst_pkg::MODE_IDENT;
                    lex_begin = lex_pos;
                    lex_len   = '0;
                    lex_take(1);
                    continue;
                end
                lex_emit(tst_pkg::KIND_ERROR, lex_pos, '0);
                lex_halted = 1'b1;
                lex_fill   = 0;
                return;
            end
            if (lex_fill == 0) begin
                if (!final_step) return;
                lex_close();
                continue;
            end
            c = lex_win[0];
            if (lex_mode == tst_pkg::MODE_IDENT) begin
                if (is_word_start(c) || is_num(c)) lex_take(1); else lex_close();
            end else if (lex_mode == tst_pkg::MODE_INT) begin
                if (is_num(c)) begin
                    lex_take(1);
                end else if (c == ".") begin
                    if (lex_fill < 2) begin
                        if (!final_step) return;
                        lex_close();
                    end else if (is_num(lex_win[1])) begin
                        lex_take(2);
                        lex_mode = tst_pkg::MODE_FRAC;
                    end else begin
                        lex_close();
                    end
                end else begin
                    lex_close();
                end
            end else begin
                if (is_num(c)) lex_take(1); else lex_close();
            end
        end
    endfunction

    // Predict the tokens caused by one accepted request
    function automatic void lex_request(logic [7:0] b, logic end_mark);
        int before_n;
        before_n = token_queue.size();
        if (lex_halted) return;
        if (!end_mark && lex_fill < WIN_DEPTH) begin
            lex_win[lex_fill] = b;
            lex_fill++;
        end
        lex_scan(end_mark);
        if (token_queue.size() > before_n) token_queue[$].last = 1'b1;
    endfunction

    function automatic void queue_text(string s);
        text_req_t r;
        for (int i = 0; i < s.len(); i++) begin
            r.text_byte   = s[i];
            r.end_marker  = 1'b0;
            r.drain_first = 1'b0;
            text_queue.push_back(r);
        end
    endfunction

    function automatic void queue_end();
        text_req_t r;
        r.text_byte   = 8'($urandom);
        r.end_marker  = 1'b1;
        r.drain_first = 1'b0;
        text_queue.push_back(r);
    endfunction

    function automatic string rand_word();
        string s;
        string pool;
        int n;
        pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
        n = $urandom_range(1, 9);
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(pool[$urandom_range(0, i == 0 ? 52 : 62)])};
        return s;
    endfunction

    function automatic string rand_digits();
        string s;
        int n;
        n = $urandom_range(1, 6);
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(8'("0") + 8'($urandom_range(0, 9)))};
        return s;
    endfunction

    // Legal random fragment: every byte drawn from the token alphabet
    function automatic string rand_piece();
        string s;
        int pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2: s = kw_text[$urandom_range(0, tst_pkg::ENTRY_COUNT - 1)];
            3:       s = {kw_text[$urandom_range(0, 8)], rand_word()};
            4:       s = rand_word();
            5:       s = rand_digits();
            6:       s = {rand_digits(), ".", rand_digits()};
            7:       s = {rand_digits(), "."};
            8:       s = kw_text[$urandom_range(0, 8)].substr(0, 1);
            default: s = "";
        endcase
        if ($urandom_range(0, 2) != 0)
            s = {s, string'($urandom_range(0, 5) == 0 ? 8'($urandom_range(9, 13)) : 8'd32)};
        return s;
    endfunction

    // Stimulus
    initial begin
        text_req_t r;
        bit drain_set;
        drain_set = 1'b0;
        lex_clear();
        queue_text("tiles 12.-.5 tabl");
        queue_end();
        queue_text("\t\n\v\f\r:=!=!12.");
        queue_end();
        while (text_queue.size() < 270) begin
            queue_text(rand_piece());
            if ($urandom_range(0, 11) == 0) queue_end();
            if (text_queue.size() > 150 && !drain_set) begin
                text_queue[$].drain_first = 1'b1;
                drain_set = 1'b1;
            end
        end
        queue_end();
        // A short identifier, an unknown byte, then text that must be swallowed silently
        queue_text("x");
        r.text_byte   = 8'h80 | 8'($urandom);
        r.end_marker  = 1'b0;
        r.drain_first = 1'b0;
        text_queue.push_back(r);
        queue_text("ab 7");
        queue_end();

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        run_live = 1'b1;
        wait (text_queue.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        while (token_queue.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("Covered %0d text bytes and %0d end markers, %0d tokens checked.",
                 bytes_sent, ends_sent, tokens_seen);
        $display("Token kinds reached: number %0d, identifier %0d, end %0d, error %0d.",
                 kind_hits[tst_pkg::KIND_NUMBER], kind_hits[tst_pkg::KIND_IDENT],
                 kind_hits[tst_pkg::KIND_END], kind_hits[tst_pkg::KIND_ERROR]);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Accept requests, predict, and check tokens at the rising edge
    always @(posedge aclk) begin
        token_exp_t t;
        req_taken <= s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            lex_request(s_tdata, s_tlast);
            if (s_tlast) ends_sent++; else bytes_sent++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            tokens_seen++;
            kind_hits[m_tdata[5:0]]++;
            if (token_queue.size() == 0) begin
                $error("token with none pending: kind %0d start %0d",
                       m_tdata[5:0], m_tdata[21:6]);
                fail_count++;
            end else begin
                t = token_queue.pop_front();
                if (m_tdata[5:0] !== t.kind) begin
                    $error("token_kind expected %0d actual %0d", t.kind, m_tdata[5:0]);
                    fail_count++;
                end
                if (m_tdata[21:6] !== t.start) begin
                    $error("token_start expected %0d actual %0d", t.start, m_tdata[21:6]);
                    fail_count++;
                end
                if (m_tdata[37:22] !== t.len) begin
                    $error("token_length expected %0d actual %0d", t.len, m_tdata[37:22]);
                    fail_count++;
                end
                if (m_tlast !== t.last) begin
                    $error("last_of_run expected %0d actual %0d", t.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Drive the next request at the falling edge, with random gaps
    always @(negedge aclk) begin
        text_req_t r;
        logic nv;
        if (run_live && !(s_tvalid && !req_taken)) begin
            nv = 1'b0;
            r.text_byte  = s_tdata;
            r.end_marker = s_tlast;
            if (send_gap > 0) begin
                send_gap--;
            end else if (text_queue.size() > 0) begin
                if (text_queue[0].drain_first && token_queue.size() != 0) begin
                    nv = 1'b0;
                end else if (text_queue.size() > 40 && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(1, 17);
                end else begin
                    r  = text_queue.pop_front();
                    nv = 1'b1;
                end
            end
            s_tvalid <= nv;
            s_tdata  <= r.text_byte;
            s_tlast  <= r.end_marker;
        end
    end

    // Stall the token side in random bursts, none near the end
    always @(negedge aclk) begin
        if (run_live) begin
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (text_queue.size() > 40 && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 16);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Hold a hard limit on run length
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ----- sim.f -----
hdl/tst_pkg.sv
hdl/tst_front.sv
hdl/tst_back.sv
hdl/tst_out.sv
hdl/tiling_script_tokenizer_core.sv
bench/tb_tiling_script_tokenizer_core.sv
